[rtl/i2a_pkg.sv]
// Shared types, mode codes and helpers for the integer to ASCII converter.
package i2a_pkg;

    localparam int ValueWidth  = 64;
    localparam int OpWidth     = 2;
    localparam int CharWidth   = 7;
    localparam int DecDigits   = 20;
    localparam int HexDigits   = ValueWidth / 4;
    localparam int BcdWidth    = DecDigits * 4;
    localparam int CountWidth  = $clog2(ValueWidth + 1);

    // Conversion modes
    typedef enum logic [OpWidth-1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_BIN  = 2'd3
    } op_t;

    localparam logic [CharWidth-1:0] CharZero  = 7'h30;
    localparam logic [CharWidth-1:0] CharA     = 7'h41;
    localparam logic [CharWidth-1:0] CharMinus = 7'h2D;

    // ASCII for one digit, 0-9 then A-F
    function automatic logic [CharWidth-1:0] digit_char(input logic [3:0] d);
        logic [CharWidth-1:0] c;
        if (d < 4'd10)
        begin
            c = CharZero + {3'b000, d};
        end
        else
        begin
            c = CharA + {3'b000, d - 4'd10};
        end
        return c;
    endfunction

endpackage

[rtl/i2a_if.sv]
// Valid/ready channel interfaces for numbers in and characters out.
interface i2a_num_if
    import i2a_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [ValueWidth-1:0] value;
    logic [OpWidth-1:0]    operation;

    modport source (output valid, output value, output operation, input ready);
    modport sink   (input valid, input value, input operation, output ready);
endinterface

interface i2a_char_if
    import i2a_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CharWidth-1:0] ascii_char;
    logic                 last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

[rtl/integer_to_ascii_digits.sv]
// Top level: 64-bit integer to ASCII decimal, hex or binary character stream.
//
// Usage: one word on the number channel (value, operation) yields a burst of
// words on the chars channel, most significant character first, with last
// set on the final one. The number channel is ready only between numbers.
// Decimal modes run a bit-serial double-dabble pass over all 64 bits into a
// 20-digit BCD register, then drop leading zero digits one per cycle, then
// send one character per cycle while the receiver is ready; a negative
// signed number sends '-' first. Hex skips the conversion pass, binary also
// skips the zero drop.
// The result sits in an output register, so a new number is taken as soon
// as the last character has been loaded there, even while it still waits.
// A stalled receiver freezes the character sequencer; nothing is dropped.
// Reset (rst_n, asynchronous) returns to idle and empties the output.
module integer_to_ascii_digits
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2a_num_if.sink     number,
    i2a_char_if.source  chars
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic                  neg_reg, neg_next;
    logic [CountWidth-1:0] cnt_reg, cnt_next;
    logic [ValueWidth-1:0] bin_reg, bin_next;
    logic [BcdWidth-1:0]   bcd_reg, bcd_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CharWidth-1:0]  char_reg, char_next;
    logic                  last_reg, last_next;

    logic                  accept;
    logic                  slot_free;
    logic [31:0]           low_word;
    logic [31:0]           mag_word;
    logic [BcdWidth-1:0]   bcd_adj;

    assign number.ready     = (state_reg == ST_IDLE);
    assign accept           = number.valid && number.ready;
    assign slot_free        = !out_valid_reg || chars.ready;
    assign chars.valid      = out_valid_reg;
    assign chars.ascii_char = char_reg;
    assign chars.last       = last_reg;

    // Magnitude of the signed low word
    assign low_word = number.value[31:0];
    assign mag_word = low_word[31] ? (~low_word + 32'd1) : low_word;

    // Double-dabble correction: add three to every BCD digit above four
    always_comb
    begin
        for (int i = 0; i < DecDigits; i++)
        begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] > 4'd4) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        out_valid_next = out_valid_reg && !chars.ready;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = op_t'(number.operation);
                    neg_next = 1'b0;
                    bcd_next = '0;
                    bin_next = number.value;
                    cnt_next = CountWidth'(ValueWidth);
                    unique case (op_t'(number.operation))
                        OP_UDEC:
                        begin
                            state_next = ST_CONV;
                        end
                        OP_SDEC:
                        begin
                            bin_next   = {32'd0, mag_word};
                            neg_next   = low_word[31];
                            state_next = ST_CONV;
                        end
                        OP_HEX:
                        begin
                            bcd_next   = {number.value, {(BcdWidth-ValueWidth){1'b0}}};
                            cnt_next   = CountWidth'(HexDigits);
                            state_next = ST_SKIP;
                        end
                        OP_BIN:
                        begin
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                // one binary bit into the BCD register per cycle
                bcd_next = {bcd_adj[BcdWidth-2:0], bin_reg[ValueWidth-1]};
                bin_next = {bin_reg[ValueWidth-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CountWidth'(1))
                begin
                    cnt_next   = CountWidth'(DecDigits);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop one leading zero digit per cycle, keep at least one
                if (bcd_reg[BcdWidth-1 -: 4] == 4'd0 && cnt_reg != CountWidth'(1))
                begin
                    bcd_next = {bcd_reg[BcdWidth-5:0], 4'd0};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        char_next = CharMinus;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end
                    else
                    begin
                        if (op_reg == OP_BIN)
                        begin
                            char_next = CharZero + {6'd0, bin_reg[ValueWidth-1]};
                            bin_next  = {bin_reg[ValueWidth-2:0], 1'b0};
                        end
                        else
                        begin
                            char_next = digit_char(bcd_reg[BcdWidth-1 -: 4]);
                            bcd_next  = {bcd_reg[BcdWidth-5:0], 4'd0};
                        end
                        last_next = (cnt_reg == CountWidth'(1));
                        cnt_next  = cnt_reg - 1'b1;
                        if (cnt_reg == CountWidth'(1))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            cnt_reg       <= '0;
            op_reg        <= OP_UDEC;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("number accepted but sequencer stayed idle");

    a_conv_decimal_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> (op_reg == OP_UDEC || op_reg == OP_SDEC))
        else $error("BCD conversion running in a non-decimal mode");

    a_minus_signed_only: assert property (@(posedge clk) disable iff (!rst_n)
        neg_reg |-> (op_reg == OP_SDEC))
        else $error("minus sign pending outside signed mode");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> (cnt_reg != '0))
        else $error("digit count ran out before the last character");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && slot_free && !neg_reg && cnt_reg == CountWidth'(1))
        |=> (state_reg == ST_IDLE && out_valid_reg && last_reg))
        else $error("final character not marked last");
`endif

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Testbench for the integer to ASCII converter: directed and random numbers, checked per character.
module tb;
    import i2a_pkg::*;

    localparam int  HoldCycles = 2500;
    localparam int  TailCycles = 100;
    localparam int  RandItems  = 500;
    localparam longint CycleLimit = 4000000;

    // One expected character word
    typedef struct packed {
        logic [CharWidth-1:0] ch;
        logic                 fin;
    } char_word_t;

    // Predicts the character stream of each accepted number and checks the output
    class digit_scoreboard;
        char_word_t expected_q[$];
        int errors;
        int chars_seen;
        int numbers_seen;
        int mode_hits[4];

        function int pending();
            return expected_q.size();
        endfunction

        // Digits of mag in base 10 or 16, most significant first, from slot pos
        function automatic int radix_digits(logic [ValueWidth-1:0] mag,
                                            logic [ValueWidth-1:0] base,
                                            ref logic [CharWidth-1:0] seq[64],
                                            input int pos);
            logic [CharWidth-1:0] rev[24];
            logic [3:0]           d;
            int                   n;
            n = 0;
            if (mag == '0)
            begin
                rev[n] = CharZero;
                n++;
            end
            while (mag != '0)
            begin
                d = 4'(mag % base);
                mag = mag / base;
                rev[n] = (d < 4'd10) ? CharZero + 7'(d) : CharA + 7'(d - 4'd10);
                n++;
            end
            for (int k = n - 1; k >= 0; k--)
            begin
                seq[pos] = rev[k];
                pos++;
            end
            return pos;
        endfunction

        // Queue the characters that one number gives
        function void note_number(logic [ValueWidth-1:0] v, op_t op);
            logic [CharWidth-1:0] seq[64];
            logic [31:0]          low;
            int                   n;
            char_word_t           w;
            n = 0;
            numbers_seen++;
            mode_hits[op]++;
            case (op)
                OP_UDEC: n = radix_digits(v, 64'd10, seq, 0);
                OP_SDEC:
                begin
                    low = v[31:0];
                    if (low[31])
                    begin
                        seq[0] = CharMinus;
                        n = 1;
                        low = -low;
                    end
                    n = radix_digits({32'd0, low}, 64'd10, seq, n);
                end
                OP_HEX:  n = radix_digits(v, 64'd16, seq, 0);
                default:
                begin
                    for (int i = 0; i < ValueWidth; i++)
                    begin
                        seq[i] = CharZero + 7'(v[ValueWidth-1-i]);
                    end
                    n = ValueWidth;
                end
            endcase
            for (int i = 0; i < n; i++)
            begin
                w.ch  = seq[i];
                w.fin = (i == n - 1);
                expected_q.push_back(w);
            end
        endfunction

        // Compare one accepted character word with the oldest expectation
        function void check_char(logic [CharWidth-1:0] ch, logic fin);
            char_word_t w;
            chars_seen++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: got char 0x%02h last=%0b with nothing expected", ch, fin);
                end
                return;
            end
            w = expected_q.pop_front();
            if (w.ch !== ch || w.fin !== fin)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: char %0d expected 0x%02h last=%0b, got 0x%02h last=%0b",
                             chars_seen, w.ch, w.fin, ch, fin);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    longint cycle_count;

    i2a_num_if  num_ch ();
    i2a_char_if chr_ch ();

    digit_scoreboard sb;

    // Sender idle pattern and receiver hold-off request
    int tx_burst;
    bit tx_quiet;
    int rx_hold_req;
    int rx_holds_done;
    int drains_done;

    integer_to_ascii_digits dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (num_ch),
        .chars  (chr_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Offer one number; returns at the edge where it is taken
    task automatic send_number(input logic [ValueWidth-1:0] v, input op_t op);
        int gap;
        @(negedge clk);
        if (tx_burst == 0)
        begin
            tx_burst = $urandom_range(1, 60);
            tx_quiet = ($urandom_range(0, 3) == 0);
        end
        tx_burst--;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            num_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        num_ch.valid     <= 1'b1;
        num_ch.value     <= v;
        num_ch.operation <= op;
        do @(posedge clk); while (!num_ch.ready);
        sb.note_number(v, op);
    endtask

    // Character receiver with random stalls and the occasional long hold-off
    initial
    begin
        int rx_burst;
        bit rx_quiet;
        int wait_n;
        rx_burst = 0;
        rx_quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_burst == 0)
            begin
                rx_burst = $urandom_range(1, 200);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            rx_burst--;
            wait_n = rx_quiet ? 0 : $urandom_range(0, 19);
            if (rx_hold_req > 0)
            begin
                wait_n += rx_hold_req;
                rx_hold_req = 0;
                rx_holds_done++;
            end
            if (wait_n > 0)
            begin
                chr_ch.ready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            chr_ch.ready <= 1'b1;
            do @(posedge clk); while (!chr_ch.valid);
            sb.check_char(chr_ch.ascii_char, chr_ch.last);
        end
    end

    // Stimulus
    initial
    begin
        logic [ValueWidth-1:0] dir_val[24];
        op_t                   dir_op[24];
        logic [ValueWidth-1:0] v;
        logic [ValueWidth-1:0] pow;
        op_t                   op;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cycle_count      = 0;
        num_ch.valid     = 1'b0;
        num_ch.value     = '0;
        num_ch.operation = OP_UDEC;
        chr_ch.ready     = 1'b0;
        tx_burst         = 0;
        tx_quiet         = 1'b0;
        rx_hold_req      = 0;
        rx_holds_done    = 0;
        drains_done      = 0;
        sb = new;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every mode, zero, most negative, ignored upper half
        dir_val = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd10000000000000000000,
                    64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                    64'd0, 64'd1, 64'h0000_0000_7FFF_FFFF, 64'h0000_0000_8000_0000,
                    64'h0000_0000_FFFF_FFFF, 64'hDEAD_BEEF_8000_0001,
                    64'hFFFF_FFFF_0000_0005,
                    64'd0, 64'hF, 64'hA, 64'hFFFF_FFFF_FFFF_FFFF,
                    64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0000,
                    64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_5555_5555, 64'd1};
        dir_op  = '{OP_UDEC, OP_UDEC, OP_UDEC, OP_UDEC, OP_UDEC, OP_UDEC, OP_UDEC,
                    OP_SDEC, OP_SDEC, OP_SDEC, OP_SDEC, OP_SDEC, OP_SDEC, OP_SDEC,
                    OP_HEX, OP_HEX, OP_HEX, OP_HEX, OP_HEX, OP_HEX,
                    OP_BIN, OP_BIN, OP_BIN, OP_BIN};
        for (int i = 0; i < 24; i++)
        begin
            send_number(dir_val[i], dir_op[i]);
        end

        // Random numbers of assorted shapes
        for (int i = 0; i < RandItems; i++)
        begin
            // long receiver hold-off while numbers keep coming
            if (i == 120 || i == 380)
            begin
                rx_hold_req = HoldCycles;
            end
            // sender waits for the output to empty
            if (i == 250 || i == 450)
            begin
                @(negedge clk);
                num_ch.valid <= 1'b0;
                while (sb.pending() != 0) @(negedge clk);
                drains_done++;
            end
            case ($urandom_range(0, 5))
                0: v = {$urandom, $urandom};
                1: v = 64'($urandom_range(0, 99));
                2: v = 64'd1 << $urandom_range(0, 63);
                3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                4:
                begin
                    pow = 64'd1;
                    repeat ($urandom_range(0, 19)) pow = pow * 64'd10;
                    v = pow + 64'($urandom_range(0, 2)) - 64'd1;
                end
                default: v = {$urandom, 32'h8000_0000 ^ 32'($urandom_range(0, 3))
                                        ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0)};
            endcase
            // binary is long, so it comes a little less often
            case ($urandom_range(0, 6))
                0, 1:    op = OP_UDEC;
                2, 3:    op = OP_SDEC;
                4, 5:    op = OP_HEX;
                default: op = OP_BIN;
            endcase
            send_number(v, op);
        end

        @(negedge clk);
        num_ch.valid <= 1'b0;

        // Let the output run dry, then watch for strays
        while (sb.pending() != 0) @(negedge clk);
        repeat (TailCycles) @(posedge clk);

        $display("covered %0d numbers (udec %0d, sdec %0d, hex %0d, bin %0d), %0d chars",
                 sb.numbers_seen, sb.mode_hits[OP_UDEC], sb.mode_hits[OP_SDEC],
                 sb.mode_hits[OP_HEX], sb.mode_hits[OP_BIN], sb.chars_seen);
        $display("long output hold-offs: %0d, input drains: %0d, mismatches: %0d",
                 rx_holds_done, drains_done, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
